/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the hash map RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HPM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HPM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HPM_ASSERT(label, clk, rst_n, prop, msg)
`define HPM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* rtl/hpm_pkg.sv */
// ----------------------------------------------------------------------------
// Hash map package
// Widths, codes and the controller to datapath signal groups.
// ----------------------------------------------------------------------------
package hpm_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned ST_W     = 2;
  localparam int unsigned TOTAL_W  = 11;
  localparam int unsigned SLOT_W   = 1 + KEY_W + VAL_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT    = 3'd0,
    CMD_GET    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_READ   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BEYOND    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_ISSUE,
    S_PROBE,
    S_LSCAN,
    S_LMOVE,
    S_LREAD,
    S_CLEAR,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    LR_POS,
    LR_CNT,
    LR_LAST
  } list_rsel_e;

  typedef struct packed {
    logic       in_ready;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       slot_rd;
    logic       slot_wr;
    logic       slot_fill;
    logic       slot_sweep;
    logic       list_rd;
    list_rsel_e list_rsel;
    logic       list_wr;
    logic       list_app;
    logic       count_inc;
    logic       count_dec;
    logic       count_clr;
    logic       set_status;
    status_e    status;
    logic       ld_value;
    logic       ld_key;
    logic       out_ld;
  } hpm_ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             in_fire;
    logic             occ;
    logic             key_hit;
    logic             list_hit;
    logic             cnt_last;
    logic             scan_last;
    logic             count_zero;
    logic             list_full;
    logic             pos_beyond;
    logic             out_free;
  } hpm_stat_t;

endpackage

/* rtl/hpm_in_if.sv */
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one command beat.
// ----------------------------------------------------------------------------
interface hpm_in_if;
  import hpm_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] key;
  logic signed [VAL_W-1:0] value_in;
  logic [POS_W-1:0] list_position;

  modport source (output valid, cmd, key, value_in, list_position, input ready);
  modport sink (input valid, cmd, key, value_in, list_position, output ready);
endinterface

/* rtl/hpm_out_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result beat.
// ----------------------------------------------------------------------------
interface hpm_out_if;
  import hpm_pkg::*;

  logic               valid;
  logic               ready;
  logic [ST_W-1:0]    status;
  logic signed [VAL_W-1:0] value_out;
  logic [KEY_W-1:0]   key_out;
  logic [TOTAL_W-1:0] key_total;

  modport source (output valid, status, value_out, key_out, key_total, input ready);
  modport sink (input valid, status, value_out, key_out, key_total, output ready);
endinterface

/* rtl/hpm_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hpm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/hpm_datapath.sv */
// ----------------------------------------------------------------------------
// Hash map datapath
// Slot and key list memories, counters, command latch and result register.
// ----------------------------------------------------------------------------
module hpm_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  hpm_in_if.sink             in_i,
  hpm_out_if.source          out_o,
  input  hpm_pkg::hpm_ctrl_t ctrl_i,
  output hpm_pkg::hpm_stat_t stat_o
);
  import hpm_pkg::*;
  `include "assert_macros.svh"

  logic [CMD_W-1:0]   cmd_q;
  logic [KEY_W-1:0]   key_q;
  logic [VAL_W-1:0]   value_q;
  logic [POS_W-1:0]   pos_q;
  logic [ADDR_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               in_fire;

  logic [ST_W-1:0]    res_status_q;
  logic [VAL_W-1:0]   res_value_q;
  logic [KEY_W-1:0]   res_key_q;

  logic               out_valid_q;
  logic [ST_W-1:0]    out_status_q;
  logic [VAL_W-1:0]   out_value_q;
  logic [KEY_W-1:0]   out_key_q;
  logic [TOTAL_W-1:0] out_total_q;

  logic [ADDR_W-1:0]  home;
  logic [ADDR_W-1:0]  slot_raddr, slot_waddr;
  logic [SLOT_W-1:0]  slot_wdata, slot_rdata;
  logic [ADDR_W-1:0]  list_raddr, list_waddr;
  logic [KEY_W-1:0]   list_wdata, list_rdata;
  logic               slot_occ;
  logic [KEY_W-1:0]   slot_key;

  assign in_fire  = in_i.valid && in_i.ready;
  assign in_i.ready = ctrl_i.in_ready;

  always_comb begin
    cnt_d = cnt_q;
    if (in_fire || ctrl_i.cnt_clr) begin
      cnt_d = '0;
    end else if (ctrl_i.cnt_inc) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctrl_i.count_clr) begin
      count_d = '0;
    end else if (ctrl_i.count_inc) begin
      count_d = count_q + 1'b1;
    end else if (ctrl_i.count_dec) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      count_q <= count_d;
      if (ctrl_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q        <= in_i.cmd;
      key_q        <= in_i.key;
      value_q      <= in_i.value_in;
      pos_q        <= in_i.list_position;
      res_status_q <= ST_OK;
      res_value_q  <= '0;
      res_key_q    <= '0;
    end else begin
      if (ctrl_i.set_status) begin
        res_status_q <= ctrl_i.status;
      end
      if (ctrl_i.ld_value) begin
        res_value_q <= slot_rdata[VAL_W-1:0];
      end
      if (ctrl_i.ld_key) begin
        res_key_q <= list_rdata;
      end
    end
    if (ctrl_i.out_ld) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_key_q    <= res_key_q;
      out_total_q  <= TOTAL_W'(count_q);
    end
  end

  assign home       = key_q[ADDR_W-1:0];
  assign slot_raddr = home + cnt_d;
  assign slot_waddr = ctrl_i.slot_sweep ? cnt_q : home + cnt_q;
  assign slot_wdata = ctrl_i.slot_fill ? {1'b1, key_q, value_q} : '0;
  assign slot_occ   = slot_rdata[SLOT_W-1];
  assign slot_key   = slot_rdata[VAL_W +: KEY_W];

  always_comb begin
    unique case (ctrl_i.list_rsel)
      LR_POS:  list_raddr = ADDR_W'(pos_q);
      LR_CNT:  list_raddr = cnt_d;
      LR_LAST: list_raddr = ADDR_W'(count_q - 1'b1);
      default: list_raddr = cnt_d;
    endcase
  end

  assign list_waddr = ctrl_i.list_app ? count_q[ADDR_W-1:0] : cnt_q;
  assign list_wdata = ctrl_i.list_app ? key_q : list_rdata;

  hpm_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(CAPACITY)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.slot_wr),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (ctrl_i.slot_rd),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  hpm_ram #(
    .WIDTH(KEY_W),
    .DEPTH(CAPACITY)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.list_wr),
    .waddr_i (list_waddr),
    .wdata_i (list_wdata),
    .re_i    (ctrl_i.list_rd),
    .raddr_i (list_raddr),
    .rdata_o (list_rdata)
  );

  always_comb begin
    stat_o.cmd        = cmd_q;
    stat_o.in_fire    = in_fire;
    stat_o.occ        = slot_occ;
    stat_o.key_hit    = slot_occ && (slot_key == key_q);
    stat_o.list_hit   = (list_rdata == key_q);
    stat_o.cnt_last   = (cnt_q == ADDR_W'(CAPACITY - 1));
    stat_o.scan_last  = (CNT_W'(cnt_q) == count_q - 1'b1);
    stat_o.count_zero = (count_q == '0);
    stat_o.list_full  = (count_q == CNT_W'(CAPACITY));
    stat_o.pos_beyond = (CNT_W'(pos_q) >= count_q);
    stat_o.out_free   = !out_valid_q || out_o.ready;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.value_out = out_value_q;
  assign out_o.key_out   = out_key_q;
  assign out_o.key_total = out_total_q;

  `HPM_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(CAPACITY), "Key count exceeds capacity.")
  `HPM_ASSERT(a_append_room, clk_i, rst_ni, (ctrl_i.list_wr && ctrl_i.list_app) |-> (count_q < CNT_W'(CAPACITY)), "Append to a full key list.")
  `HPM_ASSERT(a_slot_port, clk_i, rst_ni, !(ctrl_i.slot_rd && ctrl_i.slot_wr), "Slot read and write in one cycle.")
  `HPM_ASSERT(a_out_load, clk_i, rst_ni, ctrl_i.out_ld |=> (out_valid_q && out_total_q == TOTAL_W'($past(count_q))), "Result beat not presented after load.")

endmodule

/* rtl/hpm_ctrl.sv */
// ----------------------------------------------------------------------------
// Hash map controller
// Sequences sweeps, probes, key list scans and the result beat.
// ----------------------------------------------------------------------------
module hpm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hpm_pkg::hpm_stat_t stat_i,
  output hpm_pkg::hpm_ctrl_t ctrl_o
);
  import hpm_pkg::*;
  `include "assert_macros.svh"

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        if (stat_i.cnt_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (stat_i.in_fire) state_d = S_ISSUE;
      end
      S_ISSUE: begin
        case (stat_i.cmd) inside
          CMD_PUT, CMD_GET, CMD_REMOVE: state_d = S_PROBE;
          CMD_READ:  state_d = stat_i.pos_beyond ? S_RESP : S_LREAD;
          CMD_CLEAR: state_d = S_CLEAR;
          default:   state_d = S_RESP;
        endcase
      end
      S_PROBE: begin
        if (!stat_i.occ) begin
          state_d = S_RESP;
        end else if (stat_i.key_hit) begin
          state_d = (stat_i.cmd == CMD_REMOVE && !stat_i.count_zero) ? S_LSCAN : S_RESP;
        end else if (stat_i.cnt_last) begin
          state_d = S_RESP;
        end
      end
      S_LSCAN: begin
        if (stat_i.list_hit) begin
          state_d = S_LMOVE;
        end else if (stat_i.scan_last) begin
          state_d = S_RESP;
        end
      end
      S_LMOVE: state_d = S_RESP;
      S_LREAD: state_d = S_RESP;
      S_CLEAR: begin
        if (stat_i.cnt_last) state_d = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_INIT;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    unique case (state_q) inside
      S_INIT, S_CLEAR: begin
        ctrl_o.slot_wr    = 1'b1;
        ctrl_o.slot_sweep = 1'b1;
        ctrl_o.cnt_inc    = 1'b1;
      end
      S_IDLE: ctrl_o.in_ready = 1'b1;
      S_ISSUE: begin
        case (stat_i.cmd) inside
          CMD_PUT, CMD_GET, CMD_REMOVE: ctrl_o.slot_rd = 1'b1;
          CMD_READ: begin
            if (stat_i.pos_beyond) begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status     = ST_BEYOND;
            end else begin
              ctrl_o.list_rd   = 1'b1;
              ctrl_o.list_rsel = LR_POS;
            end
          end
          CMD_CLEAR: ctrl_o.count_clr = 1'b1;
          default: ;
        endcase
      end
      S_PROBE: begin
        if (!stat_i.occ) begin
          if (stat_i.cmd == CMD_PUT) begin
            ctrl_o.slot_wr   = 1'b1;
            ctrl_o.slot_fill = 1'b1;
            if (!stat_i.list_full) begin
              ctrl_o.list_wr   = 1'b1;
              ctrl_o.list_app  = 1'b1;
              ctrl_o.count_inc = 1'b1;
            end
          end else begin
            ctrl_o.set_status = 1'b1;
            ctrl_o.status     = ST_NOT_FOUND;
          end
        end else if (stat_i.key_hit) begin
          case (stat_i.cmd)
            CMD_PUT: begin
              ctrl_o.slot_wr   = 1'b1;
              ctrl_o.slot_fill = 1'b1;
            end
            CMD_GET: ctrl_o.ld_value = 1'b1;
            default: begin
              ctrl_o.slot_wr = 1'b1;
              if (!stat_i.count_zero) begin
                ctrl_o.cnt_clr   = 1'b1;
                ctrl_o.list_rd   = 1'b1;
                ctrl_o.list_rsel = LR_CNT;
              end
            end
          endcase
        end else if (stat_i.cnt_last) begin
          ctrl_o.set_status = 1'b1;
          ctrl_o.status     = (stat_i.cmd == CMD_PUT) ? ST_FULL : ST_NOT_FOUND;
        end else begin
          ctrl_o.cnt_inc = 1'b1;
          ctrl_o.slot_rd = 1'b1;
        end
      end
      S_LSCAN: begin
        if (stat_i.list_hit) begin
          ctrl_o.list_rd   = 1'b1;
          ctrl_o.list_rsel = LR_LAST;
        end else if (!stat_i.scan_last) begin
          ctrl_o.cnt_inc   = 1'b1;
          ctrl_o.list_rd   = 1'b1;
          ctrl_o.list_rsel = LR_CNT;
        end
      end
      S_LMOVE: begin
        ctrl_o.list_wr   = 1'b1;
        ctrl_o.count_dec = 1'b1;
      end
      S_LREAD: ctrl_o.ld_key = 1'b1;
      S_RESP: ctrl_o.out_ld = stat_i.out_free;
      default: ;
    endcase
  end

  `HPM_ASSERT(a_reset_sweep, clk_i, rst_ni, (state_q == S_IDLE && $past(state_q) == S_INIT) |-> $past(stat_i.cnt_last), "Left reset sweep early.")
  `HPM_ASSERT(a_one_beat, clk_i, rst_ni, ctrl_o.out_ld |=> (state_q == S_IDLE), "Result loaded without return to idle.")
  `HPM_ASSERT(a_accept_idle, clk_i, rst_ni, stat_i.in_fire |=> (state_q == S_ISSUE), "Command accepted outside idle.")

endmodule

/* rtl/linear_probe_hash_map_top.sv */
// Put, get and remove probe slot by slot from the home slot; a remove that hits then
// scans the key list entry by entry and moves the last key into the matching entry.
// Read fetches the key list entry at the position unless it is beyond the count; clear sweeps all slots.
// Commands are handled one at a time; the next beat can be taken in the cycle after the
// result beat is loaded, and a stalled result beat holds the controller.
// Reset: asynchronous, active low; a sweep clears all slots first.
// ----------------------------------------------------------------------------
// Linear probing hash map
// Open addressing map of 31-bit keys to 32-bit values with a key list.
// ----------------------------------------------------------------------------
module linear_probe_hash_map_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  hpm_in_if.sink    in_i,
  hpm_out_if.source out_o
);
  import hpm_pkg::*;

  hpm_ctrl_t ctrl;
  hpm_stat_t stat;

  hpm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  hpm_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

endmodule

/* tb/sv/hpm_map_checker.sv */
// ----------------------------------------------------------------------------
// Hash map result checker
// Watches the command and result channels, keeps a shadow copy of the map
// and compares every result beat field by field with its prediction.
// ----------------------------------------------------------------------------
module hpm_map_checker
  import hpm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  hpm_in_if.sink   cmd_mon,
  hpm_out_if.sink  res_mon,
  output int       error_count_o,
  output int       pending_o,
  output int       results_seen_o
);

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [VAL_W-1:0]   value_out;
    logic [KEY_W-1:0]   key_out;
    logic [TOTAL_W-1:0] key_total;
  } map_result_t;

  logic               occupied [CAPACITY];
  logic [KEY_W-1:0]   slot_keys [CAPACITY];
  logic [VAL_W-1:0]   slot_vals [CAPACITY];
  logic [KEY_W-1:0]   key_index [CAPACITY];
  int unsigned        list_len;
  map_result_t        expected_results [$];

  function automatic int find_key(logic [KEY_W-1:0] k);
    int unsigned idx;
    idx = k % CAPACITY;
    for (int n = 0; n < CAPACITY; n++) begin
      if (!occupied[idx]) return -1;
      if (slot_keys[idx] == k) return idx;
      idx = (idx + 1) % CAPACITY;
    end
    return -1;
  endfunction

  function automatic map_result_t apply_command(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                                                logic [VAL_W-1:0] v, logic [POS_W-1:0] p);
    map_result_t r;
    int unsigned idx;
    int s;
    bit placed;
    r = '0;
    r.status = ST_OK;
    case (c)
      CMD_PUT: begin
        idx = k % CAPACITY;
        placed = 0;
        for (int n = 0; n < CAPACITY; n++) begin
          if (!occupied[idx]) begin
            if (list_len < CAPACITY) begin
              key_index[list_len] = k;
              list_len++;
            end
            placed = 1;
            break;
          end
          if (slot_keys[idx] == k) begin
            placed = 1;
            break;
          end
          idx = (idx + 1) % CAPACITY;
        end
        if (placed) begin
          occupied[idx] = 1'b1;
          slot_keys[idx] = k;
          slot_vals[idx] = v;
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_GET: begin
        s = find_key(k);
        if (s < 0) r.status = ST_NOT_FOUND;
        else r.value_out = slot_vals[s];
      end
      CMD_REMOVE: begin
        s = find_key(k);
        if (s < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          occupied[s] = 1'b0;
          for (int i = 0; i < list_len; i++) begin
            if (key_index[i] == k) begin
              key_index[i] = key_index[list_len-1];
              list_len--;
              break;
            end
          end
        end
      end
      CMD_READ: begin
        if (p >= list_len) r.status = ST_BEYOND;
        else r.key_out = key_index[p];
      end
      CMD_CLEAR: begin
        for (int i = 0; i < CAPACITY; i++) occupied[i] = 1'b0;
        list_len = 0;
      end
      default: ;
    endcase
    r.key_total = list_len[TOTAL_W-1:0];
    return r;
  endfunction

  initial begin
    for (int i = 0; i < CAPACITY; i++) begin
      occupied[i] = 1'b0;
      slot_keys[i] = '0;
      slot_vals[i] = '0;
      key_index[i] = '0;
    end
    list_len = 0;
    error_count_o = 0;
    results_seen_o = 0;
  end

  assign pending_o = expected_results.size();

  always @(posedge clk_i) begin
    map_result_t got;
    map_result_t want;
    if (rst_ni) begin
      if (cmd_mon.valid && cmd_mon.ready) begin
        expected_results.push_back(apply_command(cmd_mon.cmd, cmd_mon.key,
                                                 cmd_mon.value_in, cmd_mon.list_position));
      end
      if (res_mon.valid && res_mon.ready) begin
        got = {res_mon.status, res_mon.value_out, res_mon.key_out, res_mon.key_total};
        results_seen_o <= results_seen_o + 1;
        if (expected_results.size() == 0) begin
          if (error_count_o < 10) $display("Result beat with nothing expected: %p", got);
          error_count_o <= error_count_o + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (error_count_o < 10) begin
              $display("Mismatch status %0d/%0d value %0d/%0d key %0d/%0d total %0d/%0d",
                       want.status, got.status, $signed(want.value_out),
                       $signed(got.value_out), want.key_out, got.key_out,
                       want.key_total, got.key_total);
            end
            error_count_o <= error_count_o + 1;
          end
        end
      end
    end
  end

endmodule

/* tb/sv/tb_linear_probe_hash_map_top.sv */
// ----------------------------------------------------------------------------
// Hash map testbench
// Drives directed and random put, get, remove, read, clear and undefined commands with
// random idling on both channels; a checker module predicts the results.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_map_top;
  import hpm_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   error_count;
  int   pending;
  int   results_seen;
  int   cycle_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_off;
  int   commands_sent;
  logic [KEY_W-1:0] used_keys [$];

  hpm_in_if  cmd_ch ();
  hpm_out_if res_ch ();

  linear_probe_hash_map_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch.sink),
    .out_o  (res_ch.source)
  );

  hpm_map_checker checker_inst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_mon        (cmd_ch.sink),
    .res_mon        (res_ch.sink),
    .error_count_o  (error_count),
    .pending_o      (pending),
    .results_seen_o (results_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 600000) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      res_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_command(cmd_e c, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                              logic [POS_W-1:0] p);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd <= c;
    cmd_ch.key <= k;
    cmd_ch.value_in <= v;
    cmd_ch.list_position <= p;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    commands_sent++;
    if (c == CMD_PUT) used_keys.push_back(k);
  endtask

  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(3))
      0: return KEY_W'($urandom());
      1: return KEY_W'($urandom_range(40));
      default: return (used_keys.size() > 0) ?
                      used_keys[$urandom_range(used_keys.size()-1)] :
                      KEY_W'($urandom_range(40));
    endcase
  endfunction

  task automatic random_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40) send_command(CMD_PUT, pick_key(), $urandom(), POS_W'($urandom()));
      else if (r < 65) send_command(CMD_GET, pick_key(), $urandom(), POS_W'($urandom()));
      else if (r < 82) send_command(CMD_REMOVE, pick_key(), $urandom(), POS_W'($urandom()));
      else if (r < 96) send_command(CMD_READ, pick_key(), $urandom(),
                                    POS_W'($urandom_range(1) ? $urandom_range(30)
                                                             : $urandom()));
      else if (r < 98) send_command(CMD_CLEAR, pick_key(), $urandom(), POS_W'($urandom()));
      else send_command(cmd_e'($urandom_range(7, 5)), KEY_W'($urandom()), $urandom(),
                        POS_W'($urandom()));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    hold_off = 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 61;
    commands_sent = 0;
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd = CMD_PUT;
    cmd_ch.key = '0;
    cmd_ch.value_in = '0;
    cmd_ch.list_position = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_command(CMD_READ, 0, 0, 0);
    send_command(CMD_GET, 5, 0, 0);
    send_command(CMD_REMOVE, 5, 0, 0);
    send_command(CMD_PUT, 0, 32'h8000_0000, 0);
    send_command(CMD_PUT, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_command(CMD_PUT, 1024, 32'hFFFF_FFFF, 0);
    send_command(CMD_PUT, 2048, 32'h1234_5678, 0);
    send_command(CMD_GET, 2048, 0, 0);
    send_command(CMD_PUT, 1024, 32'h5555_AAAA, 0);
    send_command(CMD_REMOVE, 1024, 0, 0);
    send_command(CMD_GET, 2048, 0, 0);
    send_command(CMD_PUT, 2048, 7, 0);
    send_command(CMD_READ, 0, 0, 3);
    send_command(CMD_READ, 0, 0, 10'h3FF);
    send_command(CMD_GET, 31'h7FFF_FFFF, 0, 0);
    send_command(cmd_e'(3'd5), 1, 1, 1);
    send_command(cmd_e'(3'd7), 31'h7FFF_FFFF, 32'hFFFF_FFFF, 10'h3FF);
    send_command(CMD_CLEAR, 0, 0, 0);
    send_command(CMD_GET, 0, 0, 0);
    send_command(CMD_READ, 0, 0, 0);

    send_idle_pct = 19;
    recv_idle_pct = 61;
    random_phase(130);

    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(20);
    join

    send_idle_pct = 61;
    recv_idle_pct = 19;
    random_phase(120);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(130);

    wait_drained();
    repeat (CAPACITY + 50) @(posedge clk_i);
    $display("Sent %0d commands and checked %0d result beats, including probe chains,",
             commands_sent, results_seen);
    $display("removal holes, key list reads, clears and a long result stall.");
    if (error_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* linear_probe_hash_map_top.f */
+incdir+rtl
rtl/hpm_pkg.sv
rtl/hpm_in_if.sv
rtl/hpm_out_if.sv
rtl/hpm_ram.sv
rtl/hpm_datapath.sv
rtl/hpm_ctrl.sv
rtl/linear_probe_hash_map_top.sv
tb/sv/hpm_map_checker.sv
tb/sv/tb_linear_probe_hash_map_top.sv
